@@ rtl/stt_pkg.sv @@
// shared types and constants for the source text tokenizer
`default_nettype none

package stt_pkg;

	localparam int KW_REGS    = 8;
	localparam int KW_W       = 64;
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;
	localparam int BURST      = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	typedef enum logic [2:0] {
		TK_NUMBER     = 3'd0,
		TK_IDENT      = 3'd1,
		TK_KEYWORD    = 3'd2,
		TK_ARITH      = 3'd3,
		TK_DELIM      = 3'd4,
		TK_ASSIGN     = 3'd5,
		TK_ERROR      = 3'd6,
		TK_END        = 3'd7
	} token_kind_t;

	typedef enum logic [1:0] {
		RUN_NONE   = 2'd0,
		RUN_NUMBER = 2'd1,
		RUN_WORD   = 2'd2
	} run_class_t;

	typedef logic [KW_REGS-1:0][KW_W-1:0] kw_array_t;

	typedef struct packed {
		token_kind_t kind;
		logic [2:0]  slot;
		logic [7:0]  ch;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [31:0] start_index;
		logic [15:0] end_line;
		logic [15:0] end_column;
		logic [31:0] end_index;
		logic [15:0] length;
		logic        last;
		logic        kw_check;
		logic [KW_W-1:0] word;
	} result_t;

	typedef struct packed {
		logic [BURST-1:0]    valid;
		result_t [BURST-1:0] rec;
	} burst_t;

	typedef struct packed {
		logic [BURST-1:0] pending;
		logic             move;
	} buf_status_t;

endpackage

`default_nettype wire

@@ rtl/stt_cfg.sv @@
// keyword register file behind the apb port
`default_nettype none

module stt_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [stt_pkg::CFG_ADDR_W-1:0]      paddr,
	input  wire logic [stt_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic      [stt_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                     pready,
	output stt_pkg::kw_array_t                       keywords
);

	stt_pkg::kw_array_t kw_q;
	logic [2:0]         sel;

	assign sel = paddr[stt_pkg::CFG_ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_q <= '0;
		end else if (psel && penable && pwrite) begin
			kw_q[sel] <= pwdata;
		end
	end

	assign prdata   = kw_q[sel];
	assign pready   = 1'b1;
	assign keywords = kw_q;

endmodule

`default_nettype wire

@@ rtl/stt_kw_match.sv @@
// parallel keyword compare, lowest slot wins
`default_nettype none

module stt_kw_match #(
	parameter int KEYWORD_SLOTS = 8
) (
	input  wire stt_pkg::kw_array_t       keywords,
	input  wire logic [stt_pkg::KW_W-1:0] word,
	input  wire logic                     check,
	output logic                          hit,
	output logic [2:0]                    slot
);

	always_comb begin
		hit  = 1'b0;
		slot = 3'd0;
		for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
			if (check && keywords[i] != '0 && keywords[i] == word) begin
				hit  = 1'b1;
				slot = 3'(i);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/stt_lex.sv @@
// per byte lexer: position counters, open run state and result burst
`default_nettype none

module stt_lex #(
	parameter int KEYWORD_CHARS = 8,
	parameter int LINE_BITS     = 16,
	parameter int INDEX_BITS    = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] text_char,
	input  wire logic       end_of_text,
	output stt_pkg::burst_t burst
);

	localparam int BW = 8 * KEYWORD_CHARS;
	localparam int LX = (LINE_BITS > 16) ? LINE_BITS : 16;
	localparam int IX = (INDEX_BITS > 32) ? INDEX_BITS : 32;

	stt_pkg::run_class_t   run_q, nrun;
	logic [LINE_BITS-1:0]  line_q, col_q, rs_line_q, rs_col_q;
	logic [INDEX_BITS-1:0] idx_q, rs_idx_q;
	logic [LINE_BITS-1:0]  line_n, col_n, nrs_line, nrs_col;
	logic [INDEX_BITS-1:0] idx_n, nrs_idx;
	logic [BW-1:0]         buf_q, nbuf;
	logic [15:0]           len_q, nlen;

	logic zero, nl, digit, alpha, wstart, space;
	logic cont, cont_word, brk, start, single, fin;
	stt_pkg::token_kind_t single_kind;
	logic [stt_pkg::BURST-1:0] v;
	stt_pkg::result_t [stt_pkg::BURST-1:0] rec;

	function automatic logic [15:0] to_line(input logic [LINE_BITS-1:0] x);
		logic [LX-1:0] w;
		w = LX'(x);
		return w[15:0];
	endfunction

	function automatic logic [31:0] to_index(input logic [INDEX_BITS-1:0] x);
		logic [IX-1:0] w;
		w = IX'(x);
		return w[31:0];
	endfunction

	function automatic stt_pkg::result_t make_rec(
		input stt_pkg::token_kind_t kind,
		input logic [7:0]            ch,
		input logic [15:0]           sl,
		input logic [15:0]           sc,
		input logic [31:0]           si,
		input logic [15:0]           el,
		input logic [15:0]           ec,
		input logic [31:0]           ei,
		input logic [15:0]           len,
		input logic                  kwc,
		input logic [stt_pkg::KW_W-1:0] word
	);
		stt_pkg::result_t r;
		r.kind         = kind;
		r.slot         = 3'd0;
		r.ch           = ch;
		r.start_line   = sl;
		r.start_column = sc;
		r.start_index  = si;
		r.end_line     = el;
		r.end_column   = ec;
		r.end_index    = ei;
		r.length       = len;
		r.last         = 1'b0;
		r.kw_check     = kwc;
		r.word         = word;
		return r;
	endfunction

	// byte classes
	always_comb begin
		zero   = text_char == stt_pkg::CH_NUL;
		nl     = text_char == stt_pkg::CH_NL;
		digit  = text_char >= stt_pkg::CH_ZERO && text_char <= stt_pkg::CH_NINE;
		alpha  = (text_char >= stt_pkg::CH_LOWER_A && text_char <= stt_pkg::CH_LOWER_Z) ||
		         (text_char >= stt_pkg::CH_UPPER_A && text_char <= stt_pkg::CH_UPPER_Z);
		wstart = alpha || text_char == stt_pkg::CH_UNDER || text_char == stt_pkg::CH_AT ||
		         text_char == stt_pkg::CH_HASH || text_char == stt_pkg::CH_DOLLAR;
		space  = text_char == stt_pkg::CH_SPACE ||
		         (text_char >= stt_pkg::CH_TAB && text_char <= stt_pkg::CH_CR);
		case (text_char)
			stt_pkg::CH_PLUS, stt_pkg::CH_MINUS,
			stt_pkg::CH_STAR, stt_pkg::CH_SLASH: single_kind = stt_pkg::TK_ARITH;
			stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN,
			stt_pkg::CH_SEMI, stt_pkg::CH_COLON: single_kind = stt_pkg::TK_DELIM;
			stt_pkg::CH_EQUAL: single_kind = stt_pkg::TK_ASSIGN;
			default: single_kind = stt_pkg::TK_ERROR;
		endcase
	end

	// saturating position of this byte
	always_comb begin
		if (nl) begin
			line_n = (&line_q) ? line_q : line_q + 1'b1;
			col_n  = '0;
		end else begin
			line_n = line_q;
			col_n  = (&col_q) ? col_q : col_q + 1'b1;
		end
		idx_n = (&idx_q) ? idx_q : idx_q + 1'b1;
	end

	// run continuation and next run state
	always_comb begin
		cont_word = run_q == stt_pkg::RUN_WORD && (wstart || digit);
		cont      = !zero && ((run_q == stt_pkg::RUN_NUMBER && digit) || cont_word);
		brk       = !cont && run_q != stt_pkg::RUN_NONE;
		start     = !zero && !cont && (digit || wstart);
		single    = !zero && !cont && !space && !digit && !wstart;
		fin       = zero || end_of_text;

		nrun     = run_q;
		nrs_line = rs_line_q;
		nrs_col  = rs_col_q;
		nrs_idx  = rs_idx_q;
		nlen     = len_q;
		nbuf     = buf_q;
		if (cont) begin
			nlen = (&len_q) ? len_q : len_q + 1'b1;
			if (cont_word) begin
				for (int i = 0; i < KEYWORD_CHARS; i++) begin
					if (len_q == 16'(i)) begin
						nbuf[8*i +: 8] = text_char;
					end
				end
			end
		end else if (start) begin
			nrun     = digit ? stt_pkg::RUN_NUMBER : stt_pkg::RUN_WORD;
			nrs_line = line_n;
			nrs_col  = col_n;
			nrs_idx  = idx_n;
			nlen     = 16'd1;
			nbuf     = digit ? '0 : BW'(text_char);
		end else begin
			nrun = stt_pkg::RUN_NONE;
			nlen = '0;
			nbuf = '0;
		end
	end

	// result burst: closed run, single byte token, run closed by end mark, end token
	always_comb begin
		v[0] = brk;
		v[1] = single;
		v[2] = !zero && end_of_text && nrun != stt_pkg::RUN_NONE;
		v[3] = fin;

		rec[0] = make_rec(
			(run_q == stt_pkg::RUN_WORD) ? stt_pkg::TK_IDENT : stt_pkg::TK_NUMBER,
			8'd0, to_line(rs_line_q), to_line(rs_col_q), to_index(rs_idx_q),
			to_line(line_n), to_line(col_n), to_index(idx_n), len_q,
			run_q == stt_pkg::RUN_WORD && len_q <= 16'(KEYWORD_CHARS),
			stt_pkg::KW_W'(buf_q));
		rec[1] = make_rec(single_kind, text_char,
			to_line(line_n), to_line(col_n), to_index(idx_n),
			to_line(line_n), to_line(col_n), to_index(idx_n), 16'd1,
			1'b0, '0);
		rec[2] = make_rec(
			(nrun == stt_pkg::RUN_WORD) ? stt_pkg::TK_IDENT : stt_pkg::TK_NUMBER,
			8'd0, to_line(nrs_line), to_line(nrs_col), to_index(nrs_idx),
			to_line(line_n), to_line(col_n), to_index(idx_n), nlen,
			nrun == stt_pkg::RUN_WORD && nlen <= 16'(KEYWORD_CHARS),
			stt_pkg::KW_W'(nbuf));
		rec[3] = make_rec(stt_pkg::TK_END, 8'd0,
			to_line(line_n), to_line(col_n), to_index(idx_n),
			to_line(line_n), to_line(col_n), to_index(idx_n), 16'd0,
			1'b0, '0);

		// mark the highest valid entry as the last of this byte
		for (int i = 0; i < stt_pkg::BURST; i++) begin
			rec[i].last = v[i] && ((v >> (i + 1)) == '0);
		end

		burst.valid = accept ? v : '0;
		burst.rec   = rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= stt_pkg::RUN_NONE;
			line_q    <= LINE_BITS'(1);
			col_q     <= '0;
			idx_q     <= '0;
			rs_line_q <= LINE_BITS'(1);
			rs_col_q  <= '0;
			rs_idx_q  <= '0;
			buf_q     <= '0;
			len_q     <= '0;
		end else if (accept) begin
			if (fin) begin
				run_q     <= stt_pkg::RUN_NONE;
				line_q    <= LINE_BITS'(1);
				col_q     <= '0;
				idx_q     <= '0;
				rs_line_q <= LINE_BITS'(1);
				rs_col_q  <= '0;
				rs_idx_q  <= '0;
				buf_q     <= '0;
				len_q     <= '0;
			end else begin
				run_q     <= nrun;
				line_q    <= line_n;
				col_q     <= col_n;
				idx_q     <= idx_n;
				rs_line_q <= nrs_line;
				rs_col_q  <= nrs_col;
				rs_idx_q  <= nrs_idx;
				buf_q     <= nbuf;
				len_q     <= nlen;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/stt_out_buf.sv @@
// pending result slots, keyword resolve and output register
`default_nettype none

module stt_out_buf #(
	parameter int KEYWORD_SLOTS = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire stt_pkg::burst_t  burst,
	input  wire stt_pkg::kw_array_t keywords,
	input  wire logic             out_stall,
	output logic                  out_valid,
	output stt_pkg::result_t      out_rec,
	output logic                  in_stall,
	output stt_pkg::buf_status_t  status
);

	logic [stt_pkg::BURST-1:0]             pend_q, head_oh;
	stt_pkg::result_t [stt_pkg::BURST-1:0] slot_q;
	stt_pkg::result_t                      head, resolved, out_q;
	logic [1:0]                            hidx;
	logic                                  out_valid_q, move, many, hit;
	logic [2:0]                            kw_slot;

	always_comb begin
		hidx = 2'd0;
		for (int i = stt_pkg::BURST - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				hidx = 2'(i);
			end
		end
		head_oh = stt_pkg::BURST'(1) << hidx;
		head    = slot_q[hidx];
	end

	stt_kw_match #(
		.KEYWORD_SLOTS(KEYWORD_SLOTS)
	) u_kw_match (
		.keywords(keywords),
		.word    (head.word),
		.check   (head.kw_check),
		.hit     (hit),
		.slot    (kw_slot)
	);

	always_comb begin
		resolved = head;
		if (hit) begin
			resolved.kind = stt_pkg::TK_KEYWORD;
			resolved.slot = kw_slot;
		end
	end

	assign move     = (|pend_q) && (!out_valid_q || !out_stall);
	assign many     = |(pend_q & (pend_q - 1'b1));
	assign in_stall = many || ((|pend_q) && !move);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= burst.valid;
		end else if (move) begin
			pend_q <= pend_q & ~head_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= burst.rec;
		end
		if (move) begin
			out_q <= resolved;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_q;
	assign status    = '{pending: pend_q, move: move};

endmodule

`default_nettype wire

@@ rtl/source_text_tokenizer.sv @@
// top level of the source text tokenizer
// The input channel takes one text byte per beat (text_char, end_of_text); a zero
// byte or a set end_of_text closes the text. The output channel gives one token per
// beat with its kind, keyword slot, single character, start and end positions,
// length and last_of_run on the final token caused by a byte.
// Keywords are written through the apb port, 64 bits each at byte address 8*i;
// pready is always high. The user must write them only while the block is idle;
// the block itself does not enforce this. Each byte's tokens are registered in the
// pending slots and then in the output register. A byte is taken every cycle as
// long as each byte causes at most one token and the receiver does not stall; a
// byte that causes more than one token holds the input while its slots drain
// through the single output register.
// Reset clears the keyword registers, the position counters (line 1, column 0,
// index 0), any open run and all pending tokens.
// When the receiver stalls, the output register holds its token, the pending
// slots fill, and in_stall rises once a new byte could not be placed.
`default_nettype none

module source_text_tokenizer #(
	parameter int KEYWORD_SLOTS = 8,
	parameter int KEYWORD_CHARS = 8,
	parameter int LINE_BITS     = 16,
	parameter int INDEX_BITS    = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [stt_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [stt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [stt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     text_char,
	input  wire logic                           end_of_text,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [2:0]                          token_kind,
	output logic [2:0]                          keyword_slot,
	output logic [7:0]                          token_char,
	output logic [15:0]                         start_line,
	output logic [15:0]                         start_column,
	output logic [31:0]                         start_index,
	output logic [15:0]                         end_line,
	output logic [15:0]                         end_column,
	output logic [31:0]                         end_index,
	output logic [15:0]                         token_length,
	output logic                                last_of_run
);

	stt_pkg::kw_array_t   keywords;
	stt_pkg::burst_t      burst;
	stt_pkg::result_t     out_rec;
	stt_pkg::buf_status_t status;
	logic                 accept;

	assign accept = in_valid && !in_stall;

	stt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.keywords(keywords)
	);

	stt_lex #(
		.KEYWORD_CHARS(KEYWORD_CHARS),
		.LINE_BITS    (LINE_BITS),
		.INDEX_BITS   (INDEX_BITS)
	) u_lex (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.text_char  (text_char),
		.end_of_text(end_of_text),
		.burst      (burst)
	);

	stt_out_buf #(
		.KEYWORD_SLOTS(KEYWORD_SLOTS)
	) u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.burst    (burst),
		.keywords (keywords),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_rec  (out_rec),
		.in_stall (in_stall),
		.status   (status)
	);

	assign token_kind   = 3'(out_rec.kind);
	assign keyword_slot = out_rec.slot;
	assign token_char   = out_rec.ch;
	assign start_line   = out_rec.start_line;
	assign start_column = out_rec.start_column;
	assign start_index  = out_rec.start_index;
	assign end_line     = out_rec.end_line;
	assign end_column   = out_rec.end_column;
	assign end_index    = out_rec.end_index;
	assign token_length = out_rec.length;
	assign last_of_run  = out_rec.last;

	// a byte is only taken when no earlier token would be overwritten
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ($countones(status.pending) == 0) ||
		           ($countones(status.pending) == 1 && status.move))
		else $error("byte accepted over pending tokens");

	// the end token is always the final token of its byte
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == 3'(stt_pkg::TK_END) |-> last_of_run)
		else $error("end token not marked last");

	// slot is only nonzero on keywords
	a_slot_kw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != 3'(stt_pkg::TK_KEYWORD) |-> keyword_slot == 3'd0)
		else $error("keyword slot on non-keyword token");

	// a beat taken with more tokens pending keeps the output valid next cycle
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (|status.pending) |=> out_valid)
		else $error("output gap while tokens pending");

endmodule

`default_nettype wire
